// ===== design/lcst_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the LRU cache set tracker.
// No dependencies; used by lcst_cell and lru_cache_set_tracker.

package lcst_pkg;

    // Request modes
    localparam logic [2:0] MODE_CHECK  = 3'd0;
    localparam logic [2:0] MODE_READ   = 3'd1;
    localparam logic [2:0] MODE_UPDATE = 3'd2;
    localparam logic [2:0] MODE_ADD    = 3'd3;
    localparam logic [2:0] MODE_INVAL  = 3'd4;

    // Field widths fixed by the interface
    localparam int MODE_W  = 3;
    localparam int KEY_W   = 32;
    localparam int STATE_W = 3;
    localparam int HELD_W  = 4;
    localparam int AW_W    = 4;

    // Sized for the largest supported set (64 ways)
    localparam int MAX_IDX_W = 6;
    localparam int MAX_CNT_W = 7;

    // Per-beat control broadcast from the top level to every cell
    typedef struct packed {
        logic                 drop_en;   // remove one line and close the gap
        logic                 drop_all;  // remove the oldest line (evict)
        logic                 load_en;   // write a line at load_idx
        logic [MAX_IDX_W-1:0] load_idx;
        logic [MAX_CNT_W-1:0] count;     // lines held before this beat
    } lcst_ctrl_t;

endpackage

// ===== design/lcst_cell.sv =====
`timescale 1ns / 1ps
// One recency slot of the set: tag and state storage, compare, and shift.
// Depends on lcst_pkg for the control struct and widths.

module lcst_cell #(
    parameter int IDX   = 0,
    parameter int TAG_W = 32
) (
    input  logic                         clk,
    input  lcst_pkg::lcst_ctrl_t         ctrl,
    input  logic [TAG_W-1:0]             key_tag,
    input  logic [lcst_pkg::STATE_W-1:0] load_state,
    input  logic [TAG_W-1:0]             up_tag,
    input  logic [lcst_pkg::STATE_W-1:0] up_state,
    input  logic                         prefix_in,
    input  logic [lcst_pkg::STATE_W-1:0] pick_in,
    output logic [TAG_W-1:0]             tag_q,
    output logic [lcst_pkg::STATE_W-1:0] state_q,
    output logic                         prefix_out,
    output logic [lcst_pkg::STATE_W-1:0] pick_out
);

    logic [TAG_W-1:0]             tag_reg;
    logic [TAG_W-1:0]             tag_next;
    logic [lcst_pkg::STATE_W-1:0] state_reg;
    logic [lcst_pkg::STATE_W-1:0] state_next;
    logic                         live;
    logic                         hit_here;
    logic                         first;
    logic                         shift;
    logic                         load;

    assign live       = lcst_pkg::MAX_CNT_W'(IDX) < ctrl.count;
    assign hit_here   = live && (tag_reg == key_tag);
    assign first      = hit_here && !prefix_in;
    assign prefix_out = prefix_in | hit_here;
    assign pick_out   = pick_in | (first ? state_reg : '0);

    // Slots at or above the dropped one take their newer neighbor
    assign shift = ctrl.drop_en && (ctrl.drop_all || prefix_out)
                   && (lcst_pkg::MAX_CNT_W'(IDX + 1) < ctrl.count);
    assign load  = ctrl.load_en && (ctrl.load_idx == lcst_pkg::MAX_IDX_W'(IDX));

    always_comb
    begin
        tag_next   = tag_reg;
        state_next = state_reg;
        if (load)
        begin
            tag_next   = key_tag;
            state_next = load_state;
        end
        else if (shift)
        begin
            tag_next   = up_tag;
            state_next = up_state;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg   <= tag_next;
        state_reg <= state_next;
    end

    assign tag_q   = tag_reg;
    assign state_q = state_reg;

endmodule

// ===== design/lru_cache_set_tracker.sv =====
`timescale 1ns / 1ps
// Top level of the LRU cache set tracker: handshake, count, control, cell row.
// Depends on lcst_pkg and lcst_cell.
//
//   Channel   Direction  Handshake            Payload
//   --------  ---------  -------------------  ------------------------------
//   request   in         in_valid / in_stall  mode, tag, line_state
//   result    out        out_valid/out_stall  found, lines_held
//   config    in         APB psel/penable     active_ways at byte address 0
//
// One beat per cycle while in_stall is low: the compare, oldest-match search
// and reorder all run through the cell row in the cycle the request beat is
// accepted, and the result lands in the output register on that edge.
// in_stall is raised only while a result waits and out_stall is high. Reset
// clears the line count, the output valid and sets active_ways to 8; tag and
// state storage is not reset and is never read before it is written.

module lru_cache_set_tracker #(
    parameter int WAYS     = 8,
    parameter int TAG_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [lcst_pkg::MODE_W-1:0]     mode,
    input  logic [lcst_pkg::KEY_W-1:0]      tag,
    input  logic [lcst_pkg::STATE_W-1:0]    line_state,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            found,
    output logic [lcst_pkg::HELD_W-1:0]     lines_held,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [1:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int CNT_W = $clog2(WAYS + 1);
    localparam int CMP_W = CNT_W + lcst_pkg::AW_W;

    // Configuration register
    logic [lcst_pkg::AW_W-1:0] ways_reg;
    logic [lcst_pkg::AW_W-1:0] ways_eff;
    logic                      cfg_wr;

    // Handshake and result register
    logic                          accept;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          found_reg;
    logic [lcst_pkg::HELD_W-1:0]   held_reg;

    // Line count
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_mid;

    // Request decode
    logic [TAG_BITS-1:0]            key;
    logic                           hit;
    logic                           full;
    logic                           is_read;
    logic                           is_update;
    logic                           is_add;
    logic                           is_inval;
    logic                           touch;
    logic                           drop;
    logic                           load;
    logic [lcst_pkg::STATE_W-1:0]   load_state;
    lcst_pkg::lcst_ctrl_t           ctrl;

    // Cell row wiring; index WAYS is the chain terminator
    logic [TAG_BITS-1:0]          tag_row    [0:WAYS];
    logic [lcst_pkg::STATE_W-1:0] state_row  [0:WAYS];
    logic                         prefix_row [0:WAYS];
    logic [lcst_pkg::STATE_W-1:0] pick_row   [0:WAYS];

    // ---------------------------------------------------------------
    // APB: always ready, one register at word 0
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == '0) ? {{(32 - lcst_pkg::AW_W){1'b0}}, ways_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ways_reg <= lcst_pkg::AW_W'(8);
        else if (cfg_wr)
            ways_reg <= pwdata[lcst_pkg::AW_W-1:0];
    end

    // A zero limit behaves as one; a limit above WAYS is capped by also
    // comparing the count against WAYS
    assign ways_eff = (ways_reg == '0) ? lcst_pkg::AW_W'(1) : ways_reg;
    assign full     = (CMP_W'(count_reg) >= CMP_W'(WAYS))
                      || (CMP_W'(count_reg) >= CMP_W'(ways_eff));

    // ---------------------------------------------------------------
    // Handshake: hold input while a result waits on a stalled output
    // ---------------------------------------------------------------
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // ---------------------------------------------------------------
    // Key: keep the low TAG_BITS, or zero-extend a wider store
    // ---------------------------------------------------------------
    generate
        if (TAG_BITS <= lcst_pkg::KEY_W)
        begin : g_key_narrow
            assign key = tag[TAG_BITS-1:0];
        end
        else
        begin : g_key_wide
            assign key = {{(TAG_BITS - lcst_pkg::KEY_W){1'b0}}, tag};
        end
    endgenerate

    // ---------------------------------------------------------------
    // Decode; unused codes fall through as a check
    // ---------------------------------------------------------------
    always_comb
    begin
        is_read   = 1'b0;
        is_update = 1'b0;
        is_add    = 1'b0;
        is_inval  = 1'b0;
        case (mode)
            lcst_pkg::MODE_READ:   is_read   = 1'b1;
            lcst_pkg::MODE_UPDATE: is_update = 1'b1;
            lcst_pkg::MODE_ADD:    is_add    = 1'b1;
            lcst_pkg::MODE_INVAL:  is_inval  = 1'b1;
            default:               ;
        endcase
    end

    assign hit   = prefix_row[WAYS];
    assign touch = (is_read || is_update) && hit;

    // Drop the match on touch/invalidate, or evict the oldest when an add
    // finds the set full. An add always has room after the eviction.
    assign drop = accept && (touch || (is_inval && hit)
                             || (is_add && full && (count_reg != '0)));
    assign load = accept && (touch || is_add);

    assign count_mid  = count_reg - CNT_W'(drop);
    assign load_state = is_read ? pick_row[WAYS] : line_state;

    always_comb
    begin
        ctrl.drop_en  = drop;
        ctrl.drop_all = is_add;
        ctrl.load_en  = load;
        ctrl.load_idx = lcst_pkg::MAX_IDX_W'(count_mid);
        ctrl.count    = lcst_pkg::MAX_CNT_W'(count_reg);
    end

    assign count_next = count_mid + CNT_W'(load);

    // ---------------------------------------------------------------
    // Cell row, oldest at index 0; the match search chains upward
    // ---------------------------------------------------------------
    assign prefix_row[0] = 1'b0;
    assign pick_row[0]   = '0;
    assign tag_row[WAYS]   = '0;
    assign state_row[WAYS] = '0;

    generate
        for (genvar i = 0; i < WAYS; i++)
        begin : g_cell
            lcst_cell #(
                .IDX   (i),
                .TAG_W (TAG_BITS)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .key_tag    (key),
                .load_state (load_state),
                .up_tag     (tag_row[i+1]),
                .up_state   (state_row[i+1]),
                .prefix_in  (prefix_row[i]),
                .pick_in    (pick_row[i]),
                .tag_q      (tag_row[i]),
                .state_q    (state_row[i]),
                .prefix_out (prefix_row[i+1]),
                .pick_out   (pick_row[i+1])
            );
        end
    endgenerate

    // ---------------------------------------------------------------
    // Count and result register
    // ---------------------------------------------------------------
    assign out_valid_next = accept ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
                count_reg <= count_next;
        end
    end

    // Advance the result payload only on an accepted beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg <= hit;
            held_reg  <= lcst_pkg::HELD_W'(count_next);
        end
    end

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign lines_held = held_reg;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for lru_cache_set_tracker: directed script, then random phases.
// Depends on lcst_pkg (mode codes) and the lru_cache_set_tracker RTL; reads no files.

module tb_top;

    localparam int SET_WAYS        = 8;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int POOL_SIZE       = 12;
    localparam int PARK_CYCLES     = 48;
    localparam int MAX_REPORTS     = 40;
    localparam int PEND_DEPTH      = 8;

    // Modes the block does not define; they must act as a check
    localparam logic [2:0] MODE_RSVD_A = 3'd5;
    localparam logic [2:0] MODE_RSVD_B = 3'd6;
    localparam logic [2:0] MODE_RSVD_C = 3'd7;

    // Register map: active_ways is the only register
    localparam logic [1:0] ADDR_ACTIVE_WAYS = 2'd0;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    // One script row: a request beat, or a register write between beats.
    // When pinned is set the expected result is taken from the row itself.
    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  op;
        logic [31:0] key;
        logic [2:0]  st;
        logic        pinned;
        logic        want_found;
        logic [3:0]  want_held;
        logic [3:0]  ways;
    } script_row_t;

    typedef struct packed {
        logic       found;
        logic [3:0] held;
    } set_outcome_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [2:0]  mode       = lcst_pkg::MODE_CHECK;
    logic [31:0] tag        = '0;
    logic [2:0]  line_state = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic        found;
    logic [3:0]  lines_held;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [1:0]  paddr      = ADDR_ACTIVE_WAYS;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;

    // Side-band that travels with the request beat: a pinned expectation
    logic        pin_valid  = 1'b0;
    logic        pin_found  = 1'b0;
    logic [3:0]  pin_held   = '0;

    lru_cache_set_tracker #(
        .WAYS     (SET_WAYS),
        .TAG_BITS (32)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .tag        (tag),
        .line_state (line_state),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .found      (found),
        .lines_held (lines_held),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Generous cap: the slowest legal run stays far below this
    initial
    begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow of the set: lines in recency order, oldest at index 0
    // ------------------------------------------------------------------
    logic [31:0]  set_tag [SET_WAYS];
    logic [2:0]   set_st  [SET_WAYS];
    int           set_cnt  = 0;
    logic [3:0]   ways_reg = 4'd8;

    // Expected results in flight, kept in a small ring
    set_outcome_t pend_buf [PEND_DEPTH];
    int           pend_head = 0;
    int           pend_tail = 0;
    int           pend_fill = 0;
    int           error_count = 0;

    // Pacing controls shared by the sender and the result sink
    bit           quiet_phase = 1'b0;
    int           park_cycles = 0;
    logic [31:0]  tag_pool [POOL_SIZE];

    // Remove the line at pos and close the gap above it
    function void drop_line(input int pos);
        for (int i = pos; i + 1 < set_cnt; i++)
        begin
            set_tag[i] = set_tag[i + 1];
            set_st[i]  = set_st[i + 1];
        end
        set_cnt--;
    endfunction

    // Move the line at pos to most recent with state st
    function void bump_line(input int pos, input logic [2:0] st);
        logic [31:0] key;
        key = set_tag[pos];
        drop_line(pos);
        set_tag[set_cnt] = key;
        set_st[set_cnt]  = st;
        set_cnt++;
    endfunction

    // Apply one request to the shadow set and return what the block must report
    function set_outcome_t advance_lru_set(input logic [2:0] op, input logic [31:0] key,
                                           input logic [2:0] st);
        set_outcome_t res;
        int           pos;
        int           limit;
        logic         hit;
        hit = 1'b0;
        pos = 0;
        // Oldest match wins, so stop at the first one
        for (int i = 0; i < set_cnt; i++)
        begin
            if (!hit && set_tag[i] == key)
            begin
                hit = 1'b1;
                pos = i;
            end
        end
        // Zero ways acts as one, anything past the set size acts as the set size
        if (ways_reg == 4'd0)
            limit = 1;
        else if (ways_reg > SET_WAYS)
            limit = SET_WAYS;
        else
            limit = ways_reg;
        case (op)
            lcst_pkg::MODE_READ:   if (hit) bump_line(pos, set_st[pos]);
            lcst_pkg::MODE_UPDATE: if (hit) bump_line(pos, st);
            lcst_pkg::MODE_INVAL:  if (hit) drop_line(pos);
            lcst_pkg::MODE_ADD:
            begin
                // Evict only the single oldest line, even if the limit was lowered
                if (set_cnt >= limit && set_cnt > 0)
                    drop_line(0);
                if (set_cnt < SET_WAYS)
                begin
                    set_tag[set_cnt] = key;
                    set_st[set_cnt]  = st;
                    set_cnt++;
                end
            end
            default: ;
        endcase
        res.found = hit;
        res.held  = 4'(set_cnt);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: check result beats, predict on request beats
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_beats
        set_outcome_t seen;
        set_outcome_t want;
        set_outcome_t model;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen.found = found;
                seen.held  = lines_held;
                if (pend_fill == 0)
                begin
                    if (error_count < MAX_REPORTS)
                        $error("result beat with nothing expected: found=%0d lines_held=%0d",
                               seen.found, seen.held);
                    error_count++;
                end
                else
                begin
                    want      = pend_buf[pend_head];
                    pend_head = (pend_head + 1) % PEND_DEPTH;
                    pend_fill--;
                    if (seen.found !== want.found)
                    begin
                        if (error_count < MAX_REPORTS)
                            $error("found: expected %0d, got %0d", want.found, seen.found);
                        error_count++;
                    end
                    if (seen.held !== want.held)
                    begin
                        if (error_count < MAX_REPORTS)
                            $error("lines_held: expected %0d, got %0d", want.held, seen.held);
                        error_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                // Always advance the shadow; a pinned row supplies its own answer
                model = advance_lru_set(mode, tag, line_state);
                if (pin_valid)
                begin
                    want.found = pin_found;
                    want.held  = pin_held;
                end
                else
                    want = model;
                if (pend_fill == PEND_DEPTH)
                begin
                    $error("too many results outstanding");
                    error_count++;
                end
                else
                begin
                    pend_buf[pend_tail] = want;
                    pend_tail = (pend_tail + 1) % PEND_DEPTH;
                    pend_fill++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pacing helpers
    // ------------------------------------------------------------------
    function int pick_gap();
        if (quiet_phase)
            return 0;
        return $urandom_range(0, 6);
    endfunction

    // Weighted so that adds keep the set populated and lookups hit often
    function logic [2:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)      return lcst_pkg::MODE_ADD;
        else if (r < 50) return lcst_pkg::MODE_READ;
        else if (r < 65) return lcst_pkg::MODE_UPDATE;
        else if (r < 80) return lcst_pkg::MODE_INVAL;
        else if (r < 90) return lcst_pkg::MODE_CHECK;
        else if (r < 94) return MODE_RSVD_A;
        else if (r < 97) return MODE_RSVD_B;
        return MODE_RSVD_C;
    endfunction

    // Mostly tags that are held or from the phase's tag pool, sometimes a fresh random one
    function logic [31:0] pick_tag();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4 && set_cnt > 0)
            return set_tag[$urandom_range(0, set_cnt - 1)];
        if (r < 8)
            return tag_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    // Offer one request beat and hold it until the block takes it
    task automatic offer_request(input logic [2:0] op, input logic [31:0] key,
                                 input logic [2:0] st, input logic pin,
                                 input logic pf, input logic [3:0] ph);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= op;
        tag        <= key;
        line_state <= st;
        pin_valid  <= pin;
        pin_found  <= pf;
        pin_held   <= ph;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Drop valid and wait until every outstanding result has been taken;
    // first let the current clock edge pass so the last accepted beat is on the books
    task automatic settle_set();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pend_fill != 0) @(posedge clk);
    endtask

    // Setup then access phase; the register lands on the access edge
    task automatic write_active_ways(input logic [31:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ACTIVE_WAYS;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        ways_reg  = word[3:0];
        // Read the register back on the next edge
        @(posedge clk);
        if (prdata !== {28'd0, word[3:0]})
        begin
            if (error_count < MAX_REPORTS)
                $error("prdata: expected %0d, got %0d", word[3:0], prdata);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result sink: random stall per beat, plus one long park on request
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int hold;
        wait (rst_n === 1'b1);
        forever
        begin
            if (park_cycles > 0)
            begin
                hold        = park_cycles;
                park_cycles = 0;
            end
            else
                hold = pick_gap();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (out_valid !== 1'b1) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Directed script. Pinned rows carry values readable straight from
    // the recency order; the rest go through the shadow set.
    // ------------------------------------------------------------------
    script_row_t directed_script [29] = '{
        // empty set after reset: every lookup misses
        '{ROW_REQ, lcst_pkg::MODE_CHECK,  32'h0000_0000, 3'd0, 1'b1, 1'b0, 4'd0, 4'd0},
        '{ROW_REQ, lcst_pkg::MODE_READ,   32'hFFFF_FFFF, 3'd0, 1'b1, 1'b0, 4'd0, 4'd0},
        '{ROW_REQ, lcst_pkg::MODE_UPDATE, 32'h0000_0005, 3'd7, 1'b1, 1'b0, 4'd0, 4'd0},
        '{ROW_REQ, lcst_pkg::MODE_INVAL,  32'h0000_0005, 3'd0, 1'b1, 1'b0, 4'd0, 4'd0},
        // fill with tag and state extremes
        '{ROW_REQ, lcst_pkg::MODE_ADD,    32'h0000_0000, 3'd0, 1'b1, 1'b0, 4'd1, 4'd0},
        '{ROW_REQ, lcst_pkg::MODE_ADD,    32'hFFFF_FFFF, 3'd7, 1'b1, 1'b0, 4'd2, 4'd0},
        '{ROW_REQ, lcst_pkg::MODE_ADD,    32'hA5A5_A5A5, 3'd5, 1'b1, 1'b0, 4'd3, 4'd0},
        '{ROW_REQ, lcst_pkg::MODE_ADD,    32'h5A5A_5A5A, 3'd2, 1'b1, 1'b0, 4'd4, 4'd0},
        // duplicate add reports the earlier copy and still appends
        '{ROW_REQ, lcst_pkg::MODE_ADD,    32'hFFFF_FFFF, 3'd3, 1'b1, 1'b1, 4'd5, 4'd0},
        '{ROW_REQ, lcst_pkg::MODE_CHECK,  32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1, 4'd5, 4'd0},
        // undefined modes act as a check
        '{ROW_REQ, MODE_RSVD_A,           32'h0000_0000, 3'd1, 1'b1, 1'b1, 4'd5, 4'd0},
        '{ROW_REQ, MODE_RSVD_B,           32'h0000_0001, 3'd6, 1'b1, 1'b0, 4'd5, 4'd0},
        '{ROW_REQ, MODE_RSVD_C,           32'hA5A5_A5A5, 3'd7, 1'b1, 1'b1, 4'd5, 4'd0},
        '{ROW_REQ, lcst_pkg::MODE_READ,   32'h0000_0000, 3'd0, 1'b1, 1'b1, 4'd5, 4'd0},
        '{ROW_REQ, lcst_pkg::MODE_UPDATE, 32'hA5A5_A5A5, 3'd6, 1'b1, 1'b1, 4'd5, 4'd0},
        // invalidate takes the oldest of the two copies
        '{ROW_REQ, lcst_pkg::MODE_INVAL,  32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1, 4'd4, 4'd0},
        '{ROW_REQ, lcst_pkg::MODE_ADD,    32'h0000_0001, 3'd1, 1'b1, 1'b0, 4'd5, 4'd0},
        '{ROW_REQ, lcst_pkg::MODE_ADD,    32'h0000_0002, 3'd2, 1'b1, 1'b0, 4'd6, 4'd0},
        '{ROW_REQ, lcst_pkg::MODE_ADD,    32'h0000_0003, 3'd4, 1'b1, 1'b0, 4'd7, 4'd0},
        '{ROW_REQ, lcst_pkg::MODE_ADD,    32'h0000_0004, 3'd6, 1'b1, 1'b0, 4'd8, 4'd0},
        // full set: add evicts the oldest line
        '{ROW_REQ, lcst_pkg::MODE_ADD,    32'h8000_0000, 3'd4, 1'b1, 1'b0, 4'd8, 4'd0},
        '{ROW_REQ, lcst_pkg::MODE_CHECK,  32'h5A5A_5A5A, 3'd0, 1'b1, 1'b0, 4'd8, 4'd0},
        '{ROW_REQ, lcst_pkg::MODE_READ,   32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, 4'd0, 4'd0},
        // zero ways acts as one: the count stays above the new limit
        '{ROW_CFG, lcst_pkg::MODE_CHECK,  32'h0000_0000, 3'd0, 1'b0, 1'b0, 4'd0, 4'd0},
        '{ROW_REQ, lcst_pkg::MODE_ADD,    32'h0000_0077, 3'd1, 1'b1, 1'b0, 4'd8, 4'd0},
        '{ROW_REQ, lcst_pkg::MODE_INVAL,  32'h0000_0077, 3'd0, 1'b1, 1'b1, 4'd7, 4'd0},
        '{ROW_REQ, lcst_pkg::MODE_ADD,    32'h0000_0078, 3'd5, 1'b1, 1'b0, 4'd7, 4'd0},
        // ways above the set size acts as the set size
        '{ROW_CFG, lcst_pkg::MODE_CHECK,  32'h0000_0000, 3'd0, 1'b0, 1'b0, 4'd0, 4'd15},
        '{ROW_REQ, lcst_pkg::MODE_ADD,    32'h0000_0079, 3'd2, 1'b1, 1'b0, 4'd8, 4'd0}
    };

    // Way settings per random phase: the extremes first, then fixed in-between values, then random picks
    int phase_ways [PHASES] = '{8, 1, 0, 15, 3, 9, 2, 5, -1, -1};

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [31:0] cfg_word;
        script_row_t row;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_script[i])
        begin
            row = directed_script[i];
            if (row.kind == ROW_CFG)
            begin
                settle_set();
                write_active_ways({28'd0, row.ways});
            end
            else
                offer_request(row.op, row.key, row.st, row.pinned, row.want_found,
                              row.want_held);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            // Reconfigure only with the set idle
            settle_set();
            cfg_word = $urandom;
            if (phase_ways[p] < 0)
                cfg_word[3:0] = 4'($urandom_range(0, 15));
            else
                cfg_word[3:0] = 4'(phase_ways[p]);
            write_active_ways(cfg_word);

            // Fresh tag pool per phase, with the all-zero and all-one tags kept in
            foreach (tag_pool[k])
                tag_pool[k] = $urandom;
            tag_pool[0] = 32'h0000_0000;
            tag_pool[1] = 32'hFFFF_FFFF;

            // Back-to-back beats on both sides in phases 4 and 7
            quiet_phase = (p == 4 || p == 7);

            // Park the sink so the output register fills and the input stalls
            if (p == 2)
                park_cycles = PARK_CYCLES;

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Pause the sender mid-phase until the pipe is empty
                if (p == 5 && n == ITEMS_PER_PHASE / 2)
                    settle_set();
                offer_request(pick_mode(), pick_tag(), 3'($urandom_range(0, 7)),
                              1'b0, 1'b0, 4'd0);
            end
        end

        settle_set();
        // Give a stray extra beat a chance to show up
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
